// ===== rtl/sm83of_pkg.sv =====
// ----------------------------------------------------------------------------
// sm83of_pkg
// shared types and constants for the sm83 operand fetch stage
// ----------------------------------------------------------------------------
package sm83of_pkg;

  // high page for register c used as an address
  localparam logic [15:0] PageHigh = 16'hFF00;

  // addressing mode codes
  localparam logic [4:0] ModeImp   = 5'd0;
  localparam logic [4:0] ModeR     = 5'd1;
  localparam logic [4:0] ModeRR    = 5'd2;
  localparam logic [4:0] ModeRD8   = 5'd3;
  localparam logic [4:0] ModeRD16  = 5'd4;
  localparam logic [4:0] ModeD16   = 5'd5;
  localparam logic [4:0] ModeMrR   = 5'd6;
  localparam logic [4:0] ModeRMr   = 5'd7;
  localparam logic [4:0] ModeRHli  = 5'd8;
  localparam logic [4:0] ModeRHld  = 5'd9;
  localparam logic [4:0] ModeHliR  = 5'd10;
  localparam logic [4:0] ModeHldR  = 5'd11;
  localparam logic [4:0] ModeRA8   = 5'd12;
  localparam logic [4:0] ModeA8R   = 5'd13;
  localparam logic [4:0] ModeHlSpr = 5'd14;
  localparam logic [4:0] ModeD8    = 5'd15;
  localparam logic [4:0] ModeA16R  = 5'd16;
  localparam logic [4:0] ModeD16R  = 5'd17;
  localparam logic [4:0] ModeMrD8  = 5'd18;
  localparam logic [4:0] ModeMr    = 5'd19;
  localparam logic [4:0] ModeRA16  = 5'd20;

  // operation codes
  localparam logic OpStart = 1'b0;
  localparam logic OpByte  = 1'b1;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhByte1 = 2'd1,
    PhByte2 = 2'd2,
    PhByte3 = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KindRequest  = 2'd0,
    KindComplete = 2'd1,
    KindError    = 2'd2
  } kind_e;

  typedef struct packed {
    phase_e      phase;
    logic [4:0]  active_mode;
    logic [7:0]  low_byte;
    logic [15:0] operand;
    logic [15:0] dest;
    logic        dest_flag;
    logic [15:0] pc;
    logic [15:0] hl;
    logic [15:0] saved_second;
    logic [1:0]  cycle_count;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] bus_address;
    logic [15:0] operand_data;
    logic [15:0] dest_address;
    logic        dest_in_memory;
    logic [15:0] pc_out;
    logic [15:0] hl_out;
    logic        hl_changed;
    logic [1:0]  cycles_used;
  } result_t;

  typedef struct packed {
    logic        operation;
    logic [4:0]  mode;
    logic [15:0] first_reg_value;
    logic [15:0] second_reg_value;
    logic        first_is_c;
    logic        second_is_c;
    logic [15:0] pc_in;
    logic [15:0] hl_in;
    logic [7:0]  bus_byte;
  } item_t;

endpackage

// ===== rtl/sm83of_step.sv =====
// ----------------------------------------------------------------------------
// sm83of_step
// next state and result for one item of the operand fetch sequencer
// ----------------------------------------------------------------------------
module sm83of_step (
  input  sm83of_pkg::state_t  state_i,
  input  sm83of_pkg::item_t   item_i,
  output sm83of_pkg::state_t  state_o,
  output logic                res_valid_o,
  output sm83of_pkg::result_t res_o
);
  import sm83of_pkg::*;

  logic        do_complete;
  logic [15:0] first_addr;
  logic [15:0] second_addr;
  logic [15:0] word;

  assign first_addr  = item_i.first_is_c  ? (item_i.first_reg_value  | PageHigh)
                                          : item_i.first_reg_value;
  assign second_addr = item_i.second_is_c ? (item_i.second_reg_value | PageHigh)
                                          : item_i.second_reg_value;
  assign word        = {item_i.bus_byte, state_i.low_byte};

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    do_complete = 1'b0;

    if (item_i.operation == OpStart) begin
      state_o.active_mode  = item_i.mode;
      state_o.dest         = '0;
      state_o.dest_flag    = 1'b0;
      state_o.pc           = item_i.pc_in;
      state_o.hl           = item_i.hl_in;
      state_o.saved_second = item_i.second_reg_value;
      state_o.cycle_count  = '0;
      state_o.low_byte     = '0;
      state_o.phase        = PhIdle;
      res_valid_o          = 1'b1;
      res_o.kind           = KindRequest;
      unique case (item_i.mode)
        ModeImp: do_complete = 1'b1;
        ModeR: begin
          state_o.operand = item_i.first_reg_value;
          do_complete     = 1'b1;
        end
        ModeRR: begin
          state_o.operand = item_i.second_reg_value;
          do_complete     = 1'b1;
        end
        ModeMrR: begin
          state_o.operand   = item_i.second_reg_value;
          state_o.dest      = first_addr;
          state_o.dest_flag = 1'b1;
          do_complete       = 1'b1;
        end
        ModeRMr: begin
          res_o.bus_address = second_addr;
          state_o.phase     = PhByte1;
        end
        ModeRHli, ModeRHld: begin
          state_o.hl        = (item_i.mode == ModeRHli) ? item_i.hl_in + 16'd1
                                                        : item_i.hl_in - 16'd1;
          res_o.bus_address = item_i.second_reg_value;
          state_o.phase     = PhByte1;
        end
        ModeHliR, ModeHldR: begin
          state_o.operand   = item_i.second_reg_value;
          state_o.dest      = item_i.first_reg_value;
          state_o.dest_flag = 1'b1;
          state_o.hl        = (item_i.mode == ModeHliR) ? item_i.hl_in + 16'd1
                                                        : item_i.hl_in - 16'd1;
          do_complete       = 1'b1;
        end
        ModeMrD8: begin
          state_o.dest      = item_i.first_reg_value;
          state_o.dest_flag = 1'b1;
          res_o.bus_address = item_i.pc_in;
          state_o.phase     = PhByte1;
        end
        ModeMr: begin
          state_o.dest      = item_i.first_reg_value;
          state_o.dest_flag = 1'b1;
          res_o.bus_address = item_i.first_reg_value;
          state_o.phase     = PhByte1;
        end
        ModeRD8, ModeRD16, ModeD16, ModeRA8, ModeA8R, ModeHlSpr, ModeD8,
        ModeA16R, ModeD16R, ModeRA16: begin
          res_o.bus_address = item_i.pc_in;
          state_o.phase     = PhByte1;
        end
        default: begin
          // unknown mode: report and fall back to idle
          res_o.kind         = KindError;
          res_o.operand_data = state_i.operand;
          res_o.pc_out       = item_i.pc_in;
          res_o.hl_out       = item_i.hl_in;
        end
      endcase
    end else if (state_i.phase != PhIdle) begin
      state_o.cycle_count = state_i.cycle_count + 2'd1;
      res_valid_o         = 1'b1;
      res_o.kind          = KindRequest;
      unique case (state_i.phase)
        PhByte1: begin
          unique case (state_i.active_mode)
            ModeRD8, ModeRA8, ModeHlSpr, ModeD8, ModeMrD8: begin
              state_o.operand = {8'd0, item_i.bus_byte};
              state_o.pc      = state_i.pc + 16'd1;
              do_complete     = 1'b1;
            end
            ModeRMr, ModeRHli, ModeRHld, ModeMr: begin
              state_o.operand = {8'd0, item_i.bus_byte};
              do_complete     = 1'b1;
            end
            ModeA8R: begin
              state_o.dest      = {8'd0, item_i.bus_byte} | PageHigh;
              state_o.dest_flag = 1'b1;
              state_o.pc        = state_i.pc + 16'd1;
              do_complete       = 1'b1;
            end
            default: begin
              state_o.low_byte  = item_i.bus_byte;
              res_o.bus_address = state_i.pc + 16'd1;
              state_o.phase     = PhByte2;
            end
          endcase
        end
        PhByte2: begin
          state_o.pc = state_i.pc + 16'd2;
          if (state_i.active_mode == ModeRA16) begin
            res_o.bus_address = word;
            state_o.phase     = PhByte3;
          end else if (state_i.active_mode == ModeA16R ||
                       state_i.active_mode == ModeD16R) begin
            state_o.dest      = word;
            state_o.dest_flag = 1'b1;
            state_o.operand   = state_i.saved_second;
            do_complete       = 1'b1;
          end else begin
            state_o.operand = word;
            do_complete     = 1'b1;
          end
        end
        default: begin
          state_o.operand = {8'd0, item_i.bus_byte};
          do_complete     = 1'b1;
        end
      endcase
    end

    if (do_complete) begin
      state_o.phase        = PhIdle;
      res_o.kind           = KindComplete;
      res_o.bus_address    = '0;
      res_o.operand_data   = state_o.operand;
      res_o.dest_address   = state_o.dest;
      res_o.dest_in_memory = state_o.dest_flag;
      res_o.pc_out         = state_o.pc;
      res_o.hl_out         = state_o.hl;
      res_o.hl_changed     = (state_o.active_mode >= ModeRHli) &&
                             (state_o.active_mode <= ModeHldR);
      res_o.cycles_used    = state_o.cycle_count;
    end
  end

endmodule

// ===== rtl/sm83_operand_fetch.sv =====
// ----------------------------------------------------------------------------
// sm83_operand_fetch
// operand fetch stage of an 8-bit sm83-style cpu
// ----------------------------------------------------------------------------
// A start item (operation 0) names the addressing mode and carries the
// operand registers, the register-c flags, pc and hl; each later item with
// operation 1 hands back the byte for the pending bus read. Every item is
// handled in the cycle it is accepted and its result, if any, appears on the
// output register at the next edge: a bus read request, a completed fetch
// or an unknown-mode error. A byte item while idle gives no result. A new
// item is taken every cycle as long as the output register is empty or
// being emptied, so the rate is one item per clock; the single sequencer
// step between the state register and the output register sets that figure.
// A start item while a fetch is pending drops the pending fetch.
// ----------------------------------------------------------------------------
module sm83_operand_fetch (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [4:0]  mode_i,
  input  logic [15:0] first_reg_value_i,
  input  logic [15:0] second_reg_value_i,
  input  logic        first_is_c_i,
  input  logic        second_is_c_i,
  input  logic [15:0] pc_in_i,
  input  logic [15:0] hl_in_i,
  input  logic [7:0]  bus_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [15:0] bus_address_o,
  output logic [15:0] operand_data_o,
  output logic [15:0] dest_address_o,
  output logic        dest_in_memory_o,
  output logic [15:0] pc_out_o,
  output logic [15:0] hl_out_o,
  output logic        hl_changed_o,
  output logic [1:0]  cycles_used_o
);
  import sm83of_pkg::*;

  // sequencer state, cleared by reset
  state_t  state_q, state_d;
  // output register
  logic    out_valid_q;
  result_t res_q;

  item_t   item;
  result_t step_res;
  logic    step_valid;
  logic    accept;

  assign item = '{
    operation:        operation_i,
    mode:             mode_i,
    first_reg_value:  first_reg_value_i,
    second_reg_value: second_reg_value_i,
    first_is_c:       first_is_c_i,
    second_is_c:      second_is_c_i,
    pc_in:            pc_in_i,
    hl_in:            hl_in_i,
    bus_byte:         bus_byte_i
  };

  // one sequencer step per accepted item
  sm83of_step u_step (
    .state_i     (state_q),
    .item_i      (item),
    .state_o     (state_d),
    .res_valid_o (step_valid),
    .res_o       (step_res)
  );

  // take a new item whenever the output slot is free or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= step_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded only alongside its valid
  always_ff @(posedge clk_i) begin
    if (accept && step_valid) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = res_q.kind;
  assign bus_address_o    = res_q.bus_address;
  assign operand_data_o   = res_q.operand_data;
  assign dest_address_o   = res_q.dest_address;
  assign dest_in_memory_o = res_q.dest_in_memory;
  assign pc_out_o         = res_q.pc_out;
  assign hl_out_o         = res_q.hl_out;
  assign hl_changed_o     = res_q.hl_changed;
  assign cycles_used_o    = res_q.cycles_used;

endmodule

// ===== rtl/sm83of_checker.sv =====
// ----------------------------------------------------------------------------
// sm83of_checker
// port-level checks for the operand fetch stage
// ----------------------------------------------------------------------------
module sm83of_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        operation_i,
  input logic [4:0]  mode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [15:0] bus_address_o,
  input logic [15:0] pc_out_o,
  input logic        dest_in_memory_o,
  input logic        hl_changed_o,
  input logic [1:0]  cycles_used_o
);
  import sm83of_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(bus_address_o) && $stable(pc_out_o))
    else $error("stalled result changed");

  // empty output slot always takes an item
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("not ready with empty output");

  // a request carries only its address
  a_req_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindRequest |->
    !dest_in_memory_o && !hl_changed_o && cycles_used_o == 2'd0 && pc_out_o == 16'd0)
    else $error("request with stray fields");

  // implied mode completes at once
  a_imp_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == OpStart && mode_i == ModeImp |=>
    out_valid_o && kind_o == KindComplete)
    else $error("implied mode did not complete");

  // unknown mode reports an error
  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == OpStart && mode_i > ModeRA16 |=>
    out_valid_o && kind_o == KindError)
    else $error("unknown mode not reported");

endmodule

bind sm83_operand_fetch sm83of_checker u_checker (.*);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sm83 operand fetch stage
// ----------------------------------------------------------------------------
// A queue of items is built up front: a short directed list covering every
// addressing mode class, the register-c page, hl and pc wrap-round, unknown
// modes, a stray byte while idle and a start that drops a pending fetch.
// After that come well-formed fetch sequences with random content, plus
// truncated sequences, unknown modes and stray bytes. A clocked driver
// offers the items with random idle bursts. A clocked monitor takes the
// results with random stalls and checks each one, field by field, against
// a behavioural model of the fetch sequencer that is run on every accepted
// item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import sm83of_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int RandomItems = 1270;
  localparam int HoldCycles = 400;
  localparam int HoldAfter = 300;
  localparam int CalmTail = 150;
  localparam int SettleCycles = 16;

  // one queued item, optionally held back until all results are in
  typedef struct {
    item_t it;
    bit    drain;
  } feed_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        operation_i = OpStart;
  logic [4:0]  mode_i = '0;
  logic [15:0] first_reg_value_i = '0;
  logic [15:0] second_reg_value_i = '0;
  logic        first_is_c_i = 1'b0;
  logic        second_is_c_i = 1'b0;
  logic [15:0] pc_in_i = '0;
  logic [15:0] hl_in_i = '0;
  logic [7:0]  bus_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [15:0] bus_address_o;
  logic [15:0] operand_data_o;
  logic [15:0] dest_address_o;
  logic        dest_in_memory_o;
  logic [15:0] pc_out_o;
  logic [15:0] hl_out_o;
  logic        hl_changed_o;
  logic [1:0]  cycles_used_o;

  sm83_operand_fetch dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .mode_i             (mode_i),
    .first_reg_value_i  (first_reg_value_i),
    .second_reg_value_i (second_reg_value_i),
    .first_is_c_i       (first_is_c_i),
    .second_is_c_i      (second_is_c_i),
    .pc_in_i            (pc_in_i),
    .hl_in_i            (hl_in_i),
    .bus_byte_i         (bus_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .kind_o             (kind_o),
    .bus_address_o      (bus_address_o),
    .operand_data_o     (operand_data_o),
    .dest_address_o     (dest_address_o),
    .dest_in_memory_o   (dest_in_memory_o),
    .pc_out_o           (pc_out_o),
    .hl_out_o           (hl_out_o),
    .hl_changed_o       (hl_changed_o),
    .cycles_used_o      (cycles_used_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  feed_t   fetch_items[$];
  result_t expected_results[$];
  int      mismatches = 0;
  int      cycle_cnt = 0;
  bit      calm = 1'b0;

  // --------------------------------------------------------------------------
  // sequencer model: its own copy of the fetch state
  // --------------------------------------------------------------------------
  phase_e      fsm_phase = PhIdle;
  logic [4:0]  cur_mode = '0;
  logic [7:0]  lo_byte = '0;
  logic [15:0] operand_q = '0;
  logic [15:0] dest_q = '0;
  logic        dest_mem = 1'b0;
  logic [15:0] pc_q = '0;
  logic [15:0] hl_q = '0;
  logic [15:0] second_q = '0;
  logic [1:0]  bus_cycles = '0;

  // read request for one byte, moving on to the given wait phase
  function automatic result_t read_req(input logic [15:0] addr, input phase_e next);
    result_t r;
    r = '0;
    r.kind = KindRequest;
    r.bus_address = addr;
    fsm_phase = next;
    return r;
  endfunction

  // completed fetch built from the model state, back to idle
  function automatic result_t fetch_done();
    result_t r;
    r = '0;
    r.kind = KindComplete;
    r.operand_data = operand_q;
    r.dest_address = dest_q;
    r.dest_in_memory = dest_mem;
    r.pc_out = pc_q;
    r.hl_out = hl_q;
    r.hl_changed = (cur_mode >= ModeRHli) && (cur_mode <= ModeHldR);
    r.cycles_used = bus_cycles;
    fsm_phase = PhIdle;
    return r;
  endfunction

  // advance the model by one accepted item; returns 1 when a result is due
  function automatic bit fetch_step(input item_t it, output result_t res);
    logic [15:0] r1;
    logic [15:0] r2;
    logic [15:0] word;
    logic [7:0]  b;
    r1 = it.first_reg_value;
    r2 = it.second_reg_value;
    b = it.bus_byte;
    res = '0;
    if (it.operation == OpStart) begin
      cur_mode = it.mode;
      dest_q = '0;
      dest_mem = 1'b0;
      pc_q = it.pc_in;
      hl_q = it.hl_in;
      second_q = r2;
      bus_cycles = '0;
      lo_byte = '0;
      case (it.mode)
        ModeImp: res = fetch_done();
        ModeR: begin
          operand_q = r1;
          res = fetch_done();
        end
        ModeRR: begin
          operand_q = r2;
          res = fetch_done();
        end
        ModeMrR: begin
          operand_q = r2;
          dest_q = it.first_is_c ? (r1 | PageHigh) : r1;
          dest_mem = 1'b1;
          res = fetch_done();
        end
        ModeRMr: res = read_req(it.second_is_c ? (r2 | PageHigh) : r2, PhByte1);
        ModeRHli: begin
          hl_q = hl_q + 16'd1;
          res = read_req(r2, PhByte1);
        end
        ModeRHld: begin
          hl_q = hl_q - 16'd1;
          res = read_req(r2, PhByte1);
        end
        ModeHliR, ModeHldR: begin
          operand_q = r2;
          dest_q = r1;
          dest_mem = 1'b1;
          hl_q = (it.mode == ModeHliR) ? hl_q + 16'd1 : hl_q - 16'd1;
          res = fetch_done();
        end
        ModeMrD8: begin
          dest_q = r1;
          dest_mem = 1'b1;
          res = read_req(pc_q, PhByte1);
        end
        ModeMr: begin
          dest_q = r1;
          dest_mem = 1'b1;
          res = read_req(r1, PhByte1);
        end
        ModeRD8, ModeRD16, ModeD16, ModeRA8, ModeA8R, ModeHlSpr, ModeD8, ModeA16R,
        ModeD16R, ModeRA16: res = read_req(pc_q, PhByte1);
        default: begin
          // unknown mode: error status, operand kept, pc and hl passed through
          fsm_phase = PhIdle;
          res.kind = KindError;
          res.operand_data = operand_q;
          res.pc_out = pc_q;
          res.hl_out = hl_q;
        end
      endcase
      return 1'b1;
    end
    // a byte with no read outstanding is dropped
    if (fsm_phase == PhIdle) return 1'b0;
    bus_cycles = bus_cycles + 2'd1;
    case (fsm_phase)
      PhByte1: begin
        case (cur_mode)
          ModeRD8, ModeRA8, ModeHlSpr, ModeD8, ModeMrD8: begin
            operand_q = {8'h00, b};
            pc_q = pc_q + 16'd1;
            res = fetch_done();
          end
          ModeRMr, ModeRHli, ModeRHld, ModeMr: begin
            operand_q = {8'h00, b};
            res = fetch_done();
          end
          ModeA8R: begin
            dest_q = PageHigh | {8'h00, b};
            dest_mem = 1'b1;
            pc_q = pc_q + 16'd1;
            res = fetch_done();
          end
          default: begin
            lo_byte = b;
            res = read_req(pc_q + 16'd1, PhByte2);
          end
        endcase
      end
      PhByte2: begin
        word = {b, lo_byte};
        pc_q = pc_q + 16'd2;
        if (cur_mode == ModeRA16) begin
          // absolute address: one more read at the fetched word
          res = read_req(word, PhByte3);
        end else begin
          if (cur_mode == ModeA16R || cur_mode == ModeD16R) begin
            dest_q = word;
            dest_mem = 1'b1;
            operand_q = second_q;
          end else begin
            operand_q = word;
          end
          res = fetch_done();
        end
      end
      default: begin
        operand_q = {8'h00, b};
        res = fetch_done();
      end
    endcase
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // extremes turn up often, the rest is uniform
  function automatic logic [15:0] rand16();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // bus reads a well-formed fetch of this mode needs
  function automatic int bytes_for(input logic [4:0] mode);
    case (mode)
      ModeRD8, ModeRMr, ModeRHli, ModeRHld, ModeRA8, ModeA8R, ModeHlSpr, ModeD8,
      ModeMrD8, ModeMr: return 1;
      ModeRD16, ModeD16, ModeA16R, ModeD16R: return 2;
      ModeRA16: return 3;
      default: return 0;
    endcase
  endfunction

  // every field random, the fields that the item does not use included
  function automatic item_t random_item();
    item_t it;
    it.operation = 1'($urandom_range(0, 1));
    it.mode = 5'($urandom_range(0, 31));
    it.first_reg_value = rand16();
    it.second_reg_value = rand16();
    it.first_is_c = 1'($urandom_range(0, 1));
    it.second_is_c = 1'($urandom_range(0, 1));
    it.pc_in = rand16();
    it.hl_in = rand16();
    it.bus_byte = rand_byte();
    return it;
  endfunction

  task automatic add_item(input item_t it, input bit drain);
    feed_t f;
    f.it = it;
    f.drain = drain;
    fetch_items.push_back(f);
  endtask

  // start item followed by nbytes returned bus bytes
  task automatic add_fetch(input logic [4:0] mode, input logic [15:0] r1, r2,
                           input bit c1, c2, input logic [15:0] pc, hl,
                           input int nbytes, input bit drain);
    item_t it;
    it = random_item();
    it.operation = OpStart;
    it.mode = mode;
    it.first_reg_value = r1;
    it.second_reg_value = r2;
    it.first_is_c = c1;
    it.second_is_c = c2;
    it.pc_in = pc;
    it.hl_in = hl;
    add_item(it, drain);
    for (int i = 0; i < nbytes; i++) begin
      it = random_item();
      it.operation = OpByte;
      add_item(it, 1'b0);
    end
  endtask

  task automatic add_stray_byte();
    item_t it;
    it = random_item();
    it.operation = OpByte;
    add_item(it, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // driver: offers queued items, random idle bursts, model run on acceptance
  // --------------------------------------------------------------------------
  item_t cur_item;
  int    gap_left = 0;
  int    idle_pct = 0;
  int    issued = 0;

  always @(posedge clk_i or negedge rst_ni) begin : driver
    result_t res;
    feed_t   pick;
    bit      nv;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      operation_i <= OpStart;
      mode_i <= '0;
      first_reg_value_i <= '0;
      second_reg_value_i <= '0;
      first_is_c_i <= 1'b0;
      second_is_c_i <= 1'b0;
      pc_in_i <= '0;
      hl_in_i <= '0;
      bus_byte_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (fetch_step(cur_item, res)) expected_results.push_back(res);
      end
      calm = fetch_items.size() < CalmTail;
      // the offer may only change once the current item has gone
      if (!in_valid_i || in_ready_o) begin
        nv = 1'b0;
        if (calm) gap_left = 0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (fetch_items.size() != 0 &&
                     !(fetch_items[0].drain && expected_results.size() != 0)) begin
          pick = fetch_items.pop_front();
          cur_item = pick.it;
          nv = 1'b1;
          operation_i <= pick.it.operation;
          mode_i <= pick.it.mode;
          first_reg_value_i <= pick.it.first_reg_value;
          second_reg_value_i <= pick.it.second_reg_value;
          first_is_c_i <= pick.it.first_is_c;
          second_is_c_i <= pick.it.second_is_c;
          pc_in_i <= pick.it.pc_in;
          hl_in_i <= pick.it.hl_in;
          bus_byte_i <= pick.it.bus_byte;
          issued++;
          // idle density changes now and then, with quiet stretches
          if (issued % 64 == 0) begin
            case ($urandom_range(0, 3))
              0, 1: idle_pct = 0;
              2: idle_pct = 25;
              default: idle_pct = 60;
            endcase
          end
          if (!calm && $urandom_range(0, 99) < idle_pct) gap_left = $urandom_range(1, 12);
        end
        in_valid_i <= nv;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random stalls, one long hold-off, per-field compare
  // --------------------------------------------------------------------------
  int results_seen = 0;
  int stall_left = 0;
  int hold_left = 0;
  int stall_pct = 0;

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    bit      rdy;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no item waiting: kind %0d", kind_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 16'(want.kind), 16'(kind_o));
          check_field("bus_address", want.bus_address, bus_address_o);
          check_field("operand_data", want.operand_data, operand_data_o);
          check_field("dest_address", want.dest_address, dest_address_o);
          check_field("dest_in_memory", 16'(want.dest_in_memory), 16'(dest_in_memory_o));
          check_field("pc_out", want.pc_out, pc_out_o);
          check_field("hl_out", want.hl_out, hl_out_o);
          check_field("hl_changed", 16'(want.hl_changed), 16'(hl_changed_o));
          check_field("cycles_used", 16'(want.cycles_used), 16'(cycles_used_o));
        end
        results_seen++;
        // long hold-off so the block fills and pushes back on its input
        if (results_seen == HoldAfter) hold_left = HoldCycles;
        if (results_seen % 64 == 0) begin
          case ($urandom_range(0, 3))
            0, 1: stall_pct = 0;
            2: stall_pct = 25;
            default: stall_pct = 60;
          endcase
        end
      end
      rdy = 1'b0;
      if (calm) stall_left = 0;
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else begin
        rdy = 1'b1;
        if (!calm && $urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 12);
      end
      out_ready_i <= rdy;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL sm83_operand_fetch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int         made;
    int         pick;
    int         n;
    int         next_drain;
    logic [4:0] m;

    // directed: byte while idle, then every mode class and the corner cases
    add_stray_byte();
    add_fetch(ModeImp, 16'h1234, 16'h5678, 1'b0, 1'b0, 16'h0100, 16'hC000, 0, 1'b0);
    add_fetch(ModeR, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 0, 1'b0);
    add_fetch(ModeRR, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 0, 1'b0);
    // register c as destination lands in the high page
    add_fetch(ModeMrR, 16'h0012, 16'hFFFF, 1'b1, 1'b0, 16'h2000, 16'h8000, 0, 1'b0);
    // hl wraps both ways
    add_fetch(ModeHliR, 16'hFFFF, 16'h00AA, 1'b0, 1'b0, 16'h3000, 16'hFFFF, 0, 1'b0);
    add_fetch(ModeHldR, 16'h0000, 16'h0055, 1'b0, 1'b0, 16'h3001, 16'h0000, 0, 1'b0);
    add_fetch(5'd21, 16'hAAAA, 16'h5555, 1'b1, 1'b1, 16'h4000, 16'h4444, 0, 1'b0);
    add_fetch(5'd31, 16'h5555, 16'hAAAA, 1'b0, 1'b1, 16'hFFFF, 16'h0000, 0, 1'b0);
    add_fetch(ModeRMr, 16'h0000, 16'h00FF, 1'b0, 1'b1, 16'h5000, 16'h1111, 1, 1'b0);
    add_fetch(ModeRHli, 16'h0001, 16'hC000, 1'b0, 1'b0, 16'h5100, 16'hFFFF, 1, 1'b0);
    // pc wraps on the immediate bytes
    add_fetch(ModeD8, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'hFFFF, 16'h0000, 1, 1'b0);
    add_fetch(ModeD16, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'hFFFE, 16'h0000, 2, 1'b0);
    add_fetch(ModeA8R, 16'h0000, 16'h0042, 1'b0, 1'b0, 16'h6000, 16'h0000, 1, 1'b0);
    add_fetch(ModeRA16, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'hFFFF, 16'h2222, 3, 1'b0);
    // a new start drops the fetch still waiting for its high byte
    add_fetch(ModeRD16, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h7000, 16'h0000, 1, 1'b0);
    add_fetch(ModeImp, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h7100, 16'h0000, 0, 1'b0);

    // random: mostly well-formed fetches, some broken sequences and noise
    made = 0;
    next_drain = 0;
    while (made < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        m = 5'($urandom_range(0, 20));
        n = bytes_for(m);
        add_fetch(m, rand16(), rand16(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  rand16(), rand16(), n, made >= next_drain);
        if (made >= next_drain) next_drain += 250;
        made += 1 + n;
      end else if (pick < 88) begin
        // truncated: the next start abandons it
        do m = 5'($urandom_range(3, 20)); while (bytes_for(m) == 0);
        n = $urandom_range(0, bytes_for(m) - 1);
        add_fetch(m, rand16(), rand16(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  rand16(), rand16(), n, 1'b0);
        made += 1 + n;
      end else if (pick < 94) begin
        add_fetch(5'($urandom_range(21, 31)), rand16(), rand16(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), rand16(), rand16(), 0, 1'b0);
        made++;
      end else begin
        add_stray_byte();
        made++;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sampled mid-cycle, once the edge's updates have settled
    while (fetch_items.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    // allow any late, unexpected result to show up
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS sm83_operand_fetch");
    end else begin
      $display("FAIL sm83_operand_fetch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sm83of_pkg.sv
rtl/sm83of_step.sv
rtl/sm83_operand_fetch.sv
rtl/sm83of_checker.sv
tb/sv/tb.sv
